[rtl/teq_pkg.sv]
// teq_pkg: shared types, widths and codes of the time ordered event queue
// used by teq_slot_ram, teq_seq and time_ordered_event_queue_top; no dependencies
package teq_pkg;

  // field widths
  localparam int unsigned TIME_W = 24;
  localparam int unsigned KIND_W = 8;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned SLOT_W = TIME_W + KIND_W + 2 * DATA_W;

  // default number of event slots
  localparam int unsigned DEFAULT_DEPTH = 64;

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // one stored event, time in the top bits
  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
  } slot_t;

endpackage

[rtl/time_ordered_event_queue_top.sv]
// Time ordered event queue: stable sorted future-event list in a ring buffer.
// Remove from empty, insert when full and insert into an empty queue answer from idle;
// a remove reads the head slot and answers from ST_REMOVE; an insert moves later events
// up in ST_SHIFT, one slot per cycle through the single read and write port, then writes
// the new event. Busy drops so the next item is taken at the edge that takes the result.
// Reset clears the event count and pointers; the results cannot be stalled.
module time_ordered_event_queue_top #(
  parameter int unsigned QueueDepth = teq_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [teq_pkg::TIME_W-1:0] event_time_i,
  input  logic [teq_pkg::KIND_W-1:0] event_kind_i,
  input  logic [teq_pkg::DATA_W-1:0] first_datum_i,
  input  logic [teq_pkg::DATA_W-1:0] second_datum_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [teq_pkg::TIME_W-1:0] out_time_o,
  output logic [teq_pkg::KIND_W-1:0] out_kind_o,
  output logic [teq_pkg::DATA_W-1:0] out_first_o,
  output logic [teq_pkg::DATA_W-1:0] out_second_o,
  output logic                       now_empty_o
);
  import teq_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [SLOT_W-1:0] mem_wdata, mem_rdata;

  // sequencer
  teq_seq #(
    .Depth (QueueDepth),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .event_time_i   (event_time_i),
    .event_kind_i   (event_kind_i),
    .first_datum_i  (first_datum_i),
    .second_datum_i (second_datum_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_time_o     (out_time_o),
    .out_kind_o     (out_kind_o),
    .out_first_o    (out_first_o),
    .out_second_o   (out_second_o),
    .now_empty_o    (now_empty_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // event slot memory
  teq_slot_ram #(
    .Depth (QueueDepth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a full queue cannot read as empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_FULL) |-> !now_empty_o)
    else $error("full result reports an empty queue");

  // a remove from an empty queue leaves it empty and returns zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STATUS_EMPTY) |-> now_empty_o && (out_time_o == '0))
    else $error("empty result with stale data");

  // a result only follows an accepted item or work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && done_o |-> $past(start && !busy) || $past(busy))
    else $error("result strobe without an item");

endmodule

[rtl/teq_slot_ram.sv]
// teq_slot_ram: event slot storage, one write port and one registered read port
// depends on teq_pkg for the slot width
module teq_slot_ram #(
  parameter int unsigned Depth = teq_pkg::DEFAULT_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [teq_pkg::SLOT_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [teq_pkg::SLOT_W-1:0] rdata_o
);
  import teq_pkg::*;

  logic [SLOT_W-1:0] mem_q [Depth];
  logic [SLOT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/teq_seq.sv]
// teq_seq: sequencer of the event queue; ring buffer pointers, one time comparator
// and one read and one write address mapper reused for every shift step; uses teq_pkg
module teq_seq #(
  parameter int unsigned Depth = teq_pkg::DEFAULT_DEPTH,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [teq_pkg::TIME_W-1:0] event_time_i,
  input  logic [teq_pkg::KIND_W-1:0] event_kind_i,
  input  logic [teq_pkg::DATA_W-1:0] first_datum_i,
  input  logic [teq_pkg::DATA_W-1:0] second_datum_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [teq_pkg::TIME_W-1:0] out_time_o,
  output logic [teq_pkg::KIND_W-1:0] out_kind_o,
  output logic [teq_pkg::DATA_W-1:0] out_first_o,
  output logic [teq_pkg::DATA_W-1:0] out_second_o,
  output logic                       now_empty_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [teq_pkg::SLOT_W-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [teq_pkg::SLOT_W-1:0] mem_rdata_i
);
  import teq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_SHIFT,
    ST_PLACE
  } state_e;

  localparam logic [AddrW:0]   DepthW    = (AddrW + 1)'(Depth);
  localparam logic [CntW-1:0]  DepthC    = CntW'(Depth);
  localparam logic [CntW-1:0]  OneC      = CntW'(1);
  localparam logic [CntW-1:0]  TwoC      = CntW'(2);
  localparam logic [AddrW-1:0] LastSlotC = AddrW'(Depth - 1);

  // logical position behind the head to physical slot, one compare and subtract
  function automatic logic [AddrW-1:0] phys_addr(input logic [AddrW-1:0] head,
                                                 input logic [CntW-1:0]  idx);
    logic [AddrW:0] sum;
    sum = {1'b0, head} + (AddrW + 1)'(idx);
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AddrW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [CntW-1:0]  j_q, j_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] head_q, head_d;
  slot_t            item_q, item_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  slot_t            res_q, res_d;
  logic             empty_q, empty_d;

  logic [CntW-1:0]  rd_idx, wr_idx;
  logic [AddrW-1:0] head_next;
  slot_t            in_slot, rd_slot;
  logic             later;

  assign in_slot = '{ev_time: event_time_i, kind: event_kind_i,
                     first: first_datum_i, second: second_datum_i};
  assign rd_slot = slot_t'(mem_rdata_i);

  // shared comparator: stored event leaves after the new one
  assign later = rd_slot.ev_time > item_q.ev_time;

  assign head_next = (head_q == LastSlotC) ? '0 : head_q + AddrW'(1);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    count_d     = count_q;
    head_d      = head_q;
    item_d      = item_q;
    done_d      = 1'b0;
    status_d    = STATUS_OK;
    res_d       = '0;
    empty_d     = empty_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_wdata_o = item_q;
    rd_idx      = '0;
    wr_idx      = j_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d = in_slot;
          if (action_i == ACT_REMOVE) begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = STATUS_EMPTY;
              empty_d  = 1'b1;
            end else begin
              mem_re_o = 1'b1;
              rd_idx   = '0;
              state_d  = ST_REMOVE;
            end
          end else if (count_q == DepthC) begin
            done_d   = 1'b1;
            status_d = STATUS_FULL;
            empty_d  = 1'b0;
          end else if (count_q == '0) begin
            mem_we_o    = 1'b1;
            wr_idx      = '0;
            mem_wdata_o = in_slot;
            count_d     = OneC;
            done_d      = 1'b1;
            empty_d     = 1'b0;
          end else begin
            mem_re_o = 1'b1;
            rd_idx   = count_q - OneC;
            j_d      = count_q;
            state_d  = ST_SHIFT;
          end
        end
      end
      ST_REMOVE: begin
        done_d  = 1'b1;
        res_d   = rd_slot;
        head_d  = head_next;
        count_d = count_q - OneC;
        empty_d = (count_q == OneC);
        state_d = ST_IDLE;
      end
      ST_SHIFT: begin
        mem_we_o = 1'b1;
        wr_idx   = j_q;
        if (later) begin
          // move the later event up one place and look at the next one down
          mem_wdata_o = mem_rdata_i;
          j_d         = j_q - OneC;
          if (j_q == OneC) begin
            state_d = ST_PLACE;
          end else begin
            mem_re_o = 1'b1;
            rd_idx   = j_q - TwoC;
          end
        end else begin
          mem_wdata_o = item_q;
          count_d     = count_q + OneC;
          done_d      = 1'b1;
          empty_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_PLACE: begin
        mem_we_o    = 1'b1;
        wr_idx      = j_q;
        mem_wdata_o = item_q;
        count_d     = count_q + OneC;
        done_d      = 1'b1;
        empty_d     = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = phys_addr(head_q, wr_idx);
  assign mem_raddr_o = phys_addr(head_q, rd_idx);

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      j_q      <= '0;
      count_q  <= '0;
      head_q   <= '0;
      item_q   <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      res_q    <= '0;
      empty_q  <= 1'b1;
    end else begin
      state_q  <= state_d;
      j_q      <= j_d;
      count_q  <= count_d;
      head_q   <= head_d;
      item_q   <= item_d;
      done_q   <= done_d;
      status_q <= status_d;
      res_q    <= res_d;
      empty_q  <= empty_d;
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign out_time_o   = res_q.ev_time;
  assign out_kind_o   = res_q.kind;
  assign out_first_o  = res_q.first;
  assign out_second_o = res_q.second;
  assign now_empty_o  = empty_q;

endmodule
